@@ hw/rtl/fbfl_pkg.sv @@
`default_nettype none

package fbfl_pkg;

    localparam int CAPACITY = 256;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 8;
    localparam int CFG_W    = 9;
    localparam int FCNT_W   = 9;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [CFG_W-1:0] INIT_BLOCKS_RST = CFG_W'(64);

    localparam logic [1:0] REG_INITIAL_BLOCKS = 2'd0;
    localparam logic [1:0] REG_AUTO_EXPAND    = 2'd1;
    localparam logic [1:0] REG_EXPAND_BLOCKS  = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOCATED  = 2'd0;
    localparam logic [1:0] ST_FREED      = 2'd1;
    localparam logic [1:0] ST_ALLOC_FAIL = 2'd2;
    localparam logic [1:0] ST_NULL_FREE  = 2'd3;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] block_index;
        logic             null_pointer;
    } fbfl_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  granted_index;
        logic [FCNT_W-1:0] free_count;
        logic [FCNT_W-1:0] total_blocks;
        logic              expanded;
    } fbfl_rsp_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fbfl_shift_t;

endpackage

`default_nettype wire

@@ hw/rtl/fbfl_cell.sv @@
`default_nettype none

module fbfl_cell (
    input  wire                            clk,
    input  fbfl_pkg::fbfl_shift_t          ctl,
    input  wire  [fbfl_pkg::IDX_W-1:0]     up_entry,
    input  wire  [fbfl_pkg::IDX_W-1:0]     down_entry,
    output logic [fbfl_pkg::IDX_W-1:0]     entry
);

    logic [fbfl_pkg::IDX_W-1:0] entry_reg;
    logic [fbfl_pkg::IDX_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push)
        begin
            entry_next = up_entry;
        end
        else if (ctl.pop)
        begin
            entry_next = down_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fbfl_stack.sv @@
`default_nettype none

module fbfl_stack (
    input  wire                            clk,
    input  fbfl_pkg::fbfl_shift_t          ctl,
    input  wire  [fbfl_pkg::IDX_W-1:0]     push_entry,
    output logic [fbfl_pkg::IDX_W-1:0]     top_entry
);

    logic [fbfl_pkg::IDX_W-1:0] entries [fbfl_pkg::CAPACITY];

    for (genvar i = 0; i < fbfl_pkg::CAPACITY; i++)
    begin : g_cell
        logic [fbfl_pkg::IDX_W-1:0] up_entry;
        logic [fbfl_pkg::IDX_W-1:0] down_entry;

        if (i == 0)
        begin : g_head
            assign up_entry = push_entry;
        end
        else
        begin : g_body
            assign up_entry = entries[i-1];
        end

        if (i == fbfl_pkg::CAPACITY - 1)
        begin : g_tail
            assign down_entry = '0;
        end
        else
        begin : g_link
            assign down_entry = entries[i+1];
        end

        fbfl_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .up_entry   (up_entry),
            .down_entry (down_entry),
            .entry      (entries[i])
        );
    end

    assign top_entry = entries[0];

endmodule

`default_nettype wire

@@ hw/rtl/fixed_block_free_list_allocator.sv @@
// A result strobes on done in the cycle after its item is accepted.
// Throughput: one item per cycle; the freed-block stack is a chain of cells
// that shifts by one entry per cycle on a push or a pop, and busy stays low.
// Reset: rst_n sets the counters, config and done to their reset values;
// stack cells and rsp are not reset. The receiver cannot stall results.
`default_nettype none

module fixed_block_free_list_allocator (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  fbfl_pkg::fbfl_req_t                req,
    output logic                               done,
    output fbfl_pkg::fbfl_rsp_t                rsp,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [fbfl_pkg::ADDR_W-1:0]        paddr,
    input  wire  [fbfl_pkg::DATA_W-1:0]        pwdata,
    output logic [fbfl_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int CNT_W = fbfl_pkg::CNT_W;
    localparam int CFG_W = fbfl_pkg::CFG_W;

    logic [CFG_W-1:0] init_reg;
    logic             auto_reg;
    logic [CFG_W-1:0] exp_reg;

    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] next_reg, next_next;
    logic [CNT_W-1:0] limit_reg, limit_next;

    logic                done_reg, done_next;
    fbfl_pkg::fbfl_rsp_t rsp_reg, rsp_next;

    fbfl_pkg::fbfl_shift_t      shift;
    logic [fbfl_pkg::IDX_W-1:0] top_entry;

    logic             accept;
    logic             cfg_wr;
    logic [1:0]       reg_sel;
    logic [CFG_W-1:0] amount;
    logic [CNT_W:0]   grown;
    logic [CNT_W-1:0] free_total;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign accept  = start && !busy;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign amount     = (exp_reg != '0) ? exp_reg : init_reg;
    assign grown      = (CNT_W+1)'(limit_reg) + (CNT_W+1)'(amount);

    always_comb
    begin
        unique case (reg_sel)
            fbfl_pkg::REG_INITIAL_BLOCKS: prdata = fbfl_pkg::DATA_W'(init_reg);
            fbfl_pkg::REG_AUTO_EXPAND:    prdata = fbfl_pkg::DATA_W'(auto_reg);
            fbfl_pkg::REG_EXPAND_BLOCKS:  prdata = fbfl_pkg::DATA_W'(exp_reg);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= fbfl_pkg::INIT_BLOCKS_RST;
            auto_reg <= 1'b0;
            exp_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                fbfl_pkg::REG_INITIAL_BLOCKS: init_reg <= pwdata[CFG_W-1:0];
                fbfl_pkg::REG_AUTO_EXPAND:    auto_reg <= pwdata[0];
                fbfl_pkg::REG_EXPAND_BLOCKS:  exp_reg  <= pwdata[CFG_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        depth_next = depth_reg;
        next_next  = next_reg;
        limit_next = limit_reg;
        shift      = '0;
        done_next  = accept;
        rsp_next   = rsp_reg;
        free_total = '0;

        if (accept)
        begin
            rsp_next.granted_index = '0;
            rsp_next.expanded      = 1'b0;
            if (req.req_type == fbfl_pkg::REQ_FREE)
            begin
                if (req.null_pointer)
                begin
                    rsp_next.status = fbfl_pkg::ST_NULL_FREE;
                end
                else
                begin
                    rsp_next.status = fbfl_pkg::ST_FREED;
                    if (depth_reg < next_reg
                        && depth_reg < CNT_W'(fbfl_pkg::CAPACITY))
                    begin
                        shift.push = 1'b1;
                        depth_next = depth_reg + CNT_W'(1);
                    end
                end
            end
            else if (depth_reg != '0)
            begin
                shift.pop              = 1'b1;
                depth_next             = depth_reg - CNT_W'(1);
                rsp_next.granted_index = top_entry;
                rsp_next.status        = fbfl_pkg::ST_ALLOCATED;
            end
            else if (next_reg < limit_reg)
            begin
                rsp_next.granted_index = next_reg[fbfl_pkg::IDX_W-1:0];
                next_next              = next_reg + CNT_W'(1);
                rsp_next.status        = fbfl_pkg::ST_ALLOCATED;
            end
            else if (auto_reg && amount != '0
                     && grown <= (CNT_W+1)'(fbfl_pkg::CAPACITY))
            begin
                limit_next             = grown[CNT_W-1:0];
                rsp_next.expanded      = 1'b1;
                rsp_next.granted_index = next_reg[fbfl_pkg::IDX_W-1:0];
                next_next              = next_reg + CNT_W'(1);
                rsp_next.status        = fbfl_pkg::ST_ALLOCATED;
            end
            else
            begin
                rsp_next.status = fbfl_pkg::ST_ALLOC_FAIL;
            end
            free_total            = depth_next + (limit_next - next_next);
            rsp_next.free_count   = free_total[fbfl_pkg::FCNT_W-1:0];
            rsp_next.total_blocks = limit_next[fbfl_pkg::FCNT_W-1:0];
        end

        if (cfg_wr && reg_sel == fbfl_pkg::REG_INITIAL_BLOCKS)
        begin
            depth_next = '0;
            next_next  = '0;
            limit_next = (pwdata[CFG_W-1:0] > CFG_W'(fbfl_pkg::CAPACITY))
                       ? CNT_W'(fbfl_pkg::CAPACITY) : CNT_W'(pwdata[CFG_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            next_reg  <= '0;
            limit_reg <= CNT_W'(fbfl_pkg::INIT_BLOCKS_RST);
            done_reg  <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            next_reg  <= next_next;
            limit_reg <= limit_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    fbfl_stack u_stack (
        .clk        (clk),
        .ctl        (shift),
        .push_entry (req.block_index),
        .top_entry  (top_entry)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after accepted item");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result strobe without accepted item");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= next_reg && next_reg <= limit_reg)
        else $error("freed stack deeper than blocks handed out");

    a_limit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        limit_reg <= CNT_W'(fbfl_pkg::CAPACITY))
        else $error("provisioned region beyond capacity");

endmodule

`default_nettype wire
